FILE: rtl/core/dlp_pkg.sv
// shared constants, types and command/status bundles for the dag longest path block
`default_nettype none

package dlp_pkg;

   localparam int MAX_NODES   = 64;
   localparam int MAX_EDGES   = 256;
   localparam int WEIGHT_BITS = 16;

   // field widths of the stream words
   localparam int NODE_W  = 6;
   localparam int WIN_W   = 16;
   localparam int SUM_W   = 22;

   localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W   = $clog2(MAX_EDGES + 1);
   localparam int LEN_W   = $clog2(MAX_NODES + 1);
   localparam int ADD_W   = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // request word layout
   localparam int REQ_FROM_LSB = 0;
   localparam int REQ_TO_LSB   = REQ_FROM_LSB + NODE_W;
   localparam int REQ_WT_LSB   = REQ_TO_LSB + NODE_W;
   localparam int REQ_SRC_LSB  = REQ_WT_LSB + WIN_W;
   localparam int REQ_SNK_LSB  = REQ_SRC_LSB + NODE_W;
   localparam int REQ_BITS     = REQ_SNK_LSB + NODE_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // response word layout
   localparam int RSP_BITS     = NODE_W + SUM_W;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W   = 2;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_NODE,
      ST_EDGE_RD,
      ST_BEST_RD,
      ST_RELAX,
      ST_NODE_END,
      ST_WALK_INIT,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic node_init;
      logic edge_rd;
      logic best_rd;
      logic relax;
      logic node_end;
      logic walk_init;
      logic walk_rd;
      logic walk_wr;
      logic out_rd;
      logic out_ld;
      logic err_ld;
   } cmd_type;

   typedef struct packed {
      logic req_run;
      logic run_bad;
      logic run_same;
      logic edges_empty;
      logic edge_last;
      logic node_last;
      logic cur_reached;
      logic walk_done;
      logic out_free;
      logic out_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/dag_longest_path.sv
// top level of the longest path engine for a topologically labeled dag
`default_nettype none

// channel   dir  width        contents
// req_*     in   tdata 40     edge_from, edge_to, weight, source_node, sink_node
//                tuser 1      mode (0 load edge, 1 run query)
// rsp_*     out  tdata 32     path_node, total_weight
//                tuser 2      reached, table_full; tlast = last
//
// an edge load takes one request word and loads are accepted back to back while idle; a run
// relaxes each node after the source up to the sink (node setup, then edge table read, best
// weight read and compare per stored edge, then node write-back), then walks and emits the path
// reset is synchronous and clears the edge count, overflow flag, state and output valid
// a stalled rsp_tready holds the result in the output register; loads and new queries
// are taken as soon as the last result of a run sits in that register

module dag_longest_path (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // edge_from, edge_to, weight, source_node, sink_node
   input  wire  [dlp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  wire                             req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // path_node, total_weight, zero pad
   output logic [dlp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // reached, table_full
   output logic [dlp_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);

   // command and status between sequencer and datapath
   dlp_pkg::cmd_type  cmd;
   dlp_pkg::stat_type stat;

   // sequencer: one word at a time, walks nodes, edges, path and output
   dlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: edge table, node stores, relax compare and output register
   dlp_data u_data (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/core/dlp_ctrl.sv
// sequencer for edge loads, node relaxation, predecessor walk and path output
`default_nettype none

module dlp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire dlp_pkg::stat_type stat,
   output dlp_pkg::cmd_type       cmd
);

   dlp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlp_pkg::ST_IDLE: begin
            if (req_tvalid && stat.req_run) begin
               if (stat.run_bad) begin
                  state_in = dlp_pkg::ST_ERR;
               end else if (stat.run_same) begin
                  state_in = dlp_pkg::ST_WALK_INIT;
               end else begin
                  state_in = dlp_pkg::ST_NODE;
               end
            end
         end
         dlp_pkg::ST_ERR: begin
            if (stat.out_free) begin
               state_in = dlp_pkg::ST_IDLE;
            end
         end
         dlp_pkg::ST_NODE: begin
            state_in = stat.edges_empty ? dlp_pkg::ST_NODE_END : dlp_pkg::ST_EDGE_RD;
         end
         dlp_pkg::ST_EDGE_RD:   state_in = dlp_pkg::ST_BEST_RD;
         dlp_pkg::ST_BEST_RD:   state_in = dlp_pkg::ST_RELAX;
         dlp_pkg::ST_RELAX: begin
            state_in = stat.edge_last ? dlp_pkg::ST_NODE_END : dlp_pkg::ST_EDGE_RD;
         end
         dlp_pkg::ST_NODE_END: begin
            if (stat.node_last) begin
               state_in = stat.cur_reached ? dlp_pkg::ST_WALK_INIT : dlp_pkg::ST_ERR;
            end else begin
               state_in = dlp_pkg::ST_NODE;
            end
         end
         dlp_pkg::ST_WALK_INIT: state_in = dlp_pkg::ST_WALK_RD;
         dlp_pkg::ST_WALK_RD: begin
            state_in = stat.walk_done ? dlp_pkg::ST_OUT_RD : dlp_pkg::ST_WALK_WR;
         end
         dlp_pkg::ST_WALK_WR:   state_in = dlp_pkg::ST_WALK_RD;
         dlp_pkg::ST_OUT_RD:    state_in = dlp_pkg::ST_OUT_WR;
         dlp_pkg::ST_OUT_WR: begin
            if (stat.out_free) begin
               state_in = stat.out_last ? dlp_pkg::ST_IDLE : dlp_pkg::ST_OUT_RD;
            end
         end
         default: state_in = dlp_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         dlp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = !stat.req_run;
               cmd.start = stat.req_run;
            end
         end
         dlp_pkg::ST_ERR:       cmd.err_ld    = stat.out_free;
         dlp_pkg::ST_NODE:      cmd.node_init = 1'b1;
         dlp_pkg::ST_EDGE_RD:   cmd.edge_rd   = 1'b1;
         dlp_pkg::ST_BEST_RD:   cmd.best_rd   = 1'b1;
         dlp_pkg::ST_RELAX:     cmd.relax     = 1'b1;
         dlp_pkg::ST_NODE_END:  cmd.node_end  = 1'b1;
         dlp_pkg::ST_WALK_INIT: cmd.walk_init = 1'b1;
         dlp_pkg::ST_WALK_RD:   cmd.walk_rd   = 1'b1;
         dlp_pkg::ST_WALK_WR:   cmd.walk_wr   = 1'b1;
         dlp_pkg::ST_OUT_RD:    cmd.out_rd    = 1'b1;
         dlp_pkg::ST_OUT_WR:    cmd.out_ld    = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/dlp_data.sv
// edge table, per-node best weight and predecessor stores, relax unit and output register
`default_nettype none

module dlp_data (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire dlp_pkg::cmd_type               cmd,
   output dlp_pkg::stat_type                   stat,
   input  wire  [dlp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                 req_tuser,
   input  wire                                 rsp_tready,
   output logic                                rsp_tvalid,
   output logic [dlp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [dlp_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);

   // request fields
   logic [dlp_pkg::NODE_W-1:0]      req_from, req_to, req_src, req_snk;
   logic [dlp_pkg::WIN_W-1:0]       req_wt;

   assign req_from = req_tdata[dlp_pkg::REQ_FROM_LSB +: dlp_pkg::NODE_W];
   assign req_to   = req_tdata[dlp_pkg::REQ_TO_LSB   +: dlp_pkg::NODE_W];
   assign req_wt   = req_tdata[dlp_pkg::REQ_WT_LSB   +: dlp_pkg::WIN_W];
   assign req_src  = req_tdata[dlp_pkg::REQ_SRC_LSB  +: dlp_pkg::NODE_W];
   assign req_snk  = req_tdata[dlp_pkg::REQ_SNK_LSB  +: dlp_pkg::NODE_W];

   // edge table
   logic [dlp_pkg::NODE_W-1:0]      efrom_mem [dlp_pkg::MAX_EDGES];
   logic [dlp_pkg::NODE_W-1:0]      eto_mem   [dlp_pkg::MAX_EDGES];
   logic [dlp_pkg::WEIGHT_BITS-1:0] ewt_mem   [dlp_pkg::MAX_EDGES];
   logic [dlp_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            ovf_ff, ovf_in;

   // per-node stores
   logic [dlp_pkg::SUM_W-1:0]       best_mem  [dlp_pkg::MAX_NODES];
   logic [dlp_pkg::NODE_W-1:0]      pred_mem  [dlp_pkg::MAX_NODES];
   logic [dlp_pkg::NODE_W-1:0]      trail_mem [dlp_pkg::MAX_NODES];
   logic [dlp_pkg::MAX_NODES-1:0]   reached_ff, reached_in;

   // run registers
   logic [dlp_pkg::NODE_W-1:0]      src_ff, snk_ff, n_ff, n_in;
   logic [dlp_pkg::EDGE_AW-1:0]     j_ff, j_in;
   logic                            cur_reached_ff, cur_reached_in;
   logic [dlp_pkg::SUM_W-1:0]       cur_best_ff, cur_best_in, total_ff, total_in;
   logic [dlp_pkg::NODE_W-1:0]      cur_pred_ff, cur_pred_in;

   // memory read registers
   logic [dlp_pkg::NODE_W-1:0]      efrom_rd_ff, eto_rd_ff, pred_rd_ff, trail_rd_ff;
   logic [dlp_pkg::WEIGHT_BITS-1:0] ewt_rd_ff;
   logic [dlp_pkg::SUM_W-1:0]       best_rd_ff;

   // walk and output
   logic [dlp_pkg::NODE_W-1:0]      wn_ff, wn_in;
   logic [dlp_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [dlp_pkg::NODE_AW-1:0]     idx_ff, idx_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dlp_pkg::NODE_W-1:0]      rsp_node_ff;
   logic [dlp_pkg::SUM_W-1:0]       rsp_total_ff;
   logic                            rsp_reached_ff, rsp_full_ff, rsp_last_ff;

   logic                            out_free, table_clear, edge_hit, take;
   logic [dlp_pkg::ADD_W-1:0]       sum;
   logic [dlp_pkg::SUM_W-1:0]       cand;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign table_clear = cmd.err_ld || (cmd.out_ld && (idx_ff == '0));

   // relax: saturating candidate and strict compare
   assign sum  = dlp_pkg::ADD_W'(best_rd_ff) + dlp_pkg::ADD_W'(ewt_rd_ff);
   assign cand = (sum > dlp_pkg::ADD_W'(dlp_pkg::SUM_MAX)) ?
                 dlp_pkg::SUM_MAX : sum[dlp_pkg::SUM_W-1:0];
   assign edge_hit = (eto_rd_ff == n_ff) && (efrom_rd_ff >= src_ff) &&
                     (efrom_rd_ff < n_ff) && reached_ff[efrom_rd_ff[dlp_pkg::NODE_AW-1:0]];
   assign take = edge_hit && (!cur_reached_ff || (cand > cur_best_ff));

   always_comb begin
      stat.req_run     = (req_tuser == dlp_pkg::MODE_RUN);
      stat.run_bad     = (req_snk < req_src) ||
                         ({1'b0, req_src} >= (dlp_pkg::NODE_W+1)'(dlp_pkg::MAX_NODES)) ||
                         ({1'b0, req_snk} >= (dlp_pkg::NODE_W+1)'(dlp_pkg::MAX_NODES));
      stat.run_same    = (req_snk == req_src);
      stat.edges_empty = (count_ff == '0);
      stat.edge_last   = ((dlp_pkg::CNT_W'(j_ff) + 1'b1) == count_ff);
      stat.node_last   = (n_ff == snk_ff);
      stat.cur_reached = cur_reached_ff;
      stat.walk_done   = (wn_ff == src_ff) || (len_ff == dlp_pkg::LEN_W'(dlp_pkg::MAX_NODES));
      stat.out_free    = out_free;
      stat.out_last    = (idx_ff == '0);
   end

   // next values of control and run registers
   always_comb begin
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      reached_in     = reached_ff;
      n_in           = n_ff;
      j_in           = j_ff;
      cur_reached_in = cur_reached_ff;
      cur_best_in    = cur_best_ff;
      cur_pred_in    = cur_pred_ff;
      total_in       = total_ff;
      wn_in          = wn_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         if (count_ff < dlp_pkg::CNT_W'(dlp_pkg::MAX_EDGES)) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.start) begin
         reached_in = '0;
         reached_in[req_src[dlp_pkg::NODE_AW-1:0]] = 1'b1;
         n_in     = req_src + 1'b1;
         total_in = '0;
      end
      if (cmd.node_init) begin
         j_in           = '0;
         cur_reached_in = 1'b0;
      end
      if (cmd.relax) begin
         j_in = j_ff + 1'b1;
         if (take) begin
            cur_reached_in = 1'b1;
            cur_best_in    = cand;
            cur_pred_in    = efrom_rd_ff;
         end
      end
      if (cmd.node_end) begin
         reached_in[n_ff[dlp_pkg::NODE_AW-1:0]] = cur_reached_ff;
         if (n_ff == snk_ff) begin
            total_in = cur_best_ff;
         end else begin
            n_in = n_ff + 1'b1;
         end
      end
      if (cmd.walk_init) begin
         wn_in  = snk_ff;
         len_in = dlp_pkg::LEN_W'(1);
      end
      if (cmd.walk_rd && stat.walk_done) begin
         idx_in = dlp_pkg::NODE_AW'(len_ff - 1'b1);
      end
      if (cmd.walk_wr) begin
         wn_in  = pred_rd_ff;
         len_in = len_ff + 1'b1;
      end
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
         if (idx_ff != '0) begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (cmd.err_ld) begin
         rsp_valid_in = 1'b1;
      end
      if (table_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reached_ff     <= reached_in;
      n_ff           <= n_in;
      j_ff           <= j_in;
      cur_reached_ff <= cur_reached_in;
      cur_best_ff    <= cur_best_in;
      cur_pred_ff    <= cur_pred_in;
      total_ff       <= total_in;
      wn_ff          <= wn_in;
      len_ff         <= len_in;
      idx_ff         <= idx_in;
      if (cmd.start) begin
         src_ff <= req_src;
         snk_ff <= req_snk;
      end
   end

   // edge table port
   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < dlp_pkg::CNT_W'(dlp_pkg::MAX_EDGES))) begin
         efrom_mem[count_ff[dlp_pkg::EDGE_AW-1:0]] <= req_from;
         eto_mem[count_ff[dlp_pkg::EDGE_AW-1:0]]   <= req_to;
         ewt_mem[count_ff[dlp_pkg::EDGE_AW-1:0]]   <= req_wt[dlp_pkg::WEIGHT_BITS-1:0];
      end
      if (cmd.edge_rd) begin
         efrom_rd_ff <= efrom_mem[j_ff];
         eto_rd_ff   <= eto_mem[j_ff];
         ewt_rd_ff   <= ewt_mem[j_ff];
      end
   end

   // best weight and predecessor stores
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_mem[req_src[dlp_pkg::NODE_AW-1:0]] <= '0;
         pred_mem[req_src[dlp_pkg::NODE_AW-1:0]] <= req_src;
      end else if (cmd.node_end) begin
         best_mem[n_ff[dlp_pkg::NODE_AW-1:0]] <= cur_best_ff;
         pred_mem[n_ff[dlp_pkg::NODE_AW-1:0]] <= cur_pred_ff;
      end
      if (cmd.best_rd) begin
         best_rd_ff <= best_mem[efrom_rd_ff[dlp_pkg::NODE_AW-1:0]];
      end
      if (cmd.walk_rd) begin
         pred_rd_ff <= pred_mem[wn_ff[dlp_pkg::NODE_AW-1:0]];
      end
   end

   // path trail, written sink first and read back source first
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         trail_mem[0] <= snk_ff;
      end else if (cmd.walk_wr) begin
         trail_mem[len_ff[dlp_pkg::NODE_AW-1:0]] <= pred_rd_ff;
      end
      if (cmd.out_rd) begin
         trail_rd_ff <= trail_mem[idx_ff];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.err_ld) begin
         rsp_node_ff    <= src_ff;
         rsp_total_ff   <= '0;
         rsp_reached_ff <= 1'b0;
         rsp_full_ff    <= ovf_ff;
         rsp_last_ff    <= 1'b1;
      end else if (cmd.out_ld) begin
         rsp_node_ff    <= trail_rd_ff;
         rsp_total_ff   <= total_ff;
         rsp_reached_ff <= 1'b1;
         rsp_full_ff    <= ovf_ff;
         rsp_last_ff    <= (idx_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dlp_pkg::RSP_DATA_W'({rsp_total_ff, rsp_node_ff});
   assign rsp_tuser  = {rsp_full_ff, rsp_reached_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_table_cleared: assert property (@(posedge clock) disable iff (reset)
      table_clear |=> (count_ff == '0) && !ovf_ff)
      else $error("edge table not emptied after run");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dlp_pkg::CNT_W'(dlp_pkg::MAX_EDGES))
      else $error("edge count beyond table depth");

   a_relax_monotone: assert property (@(posedge clock) disable iff (reset)
      cmd.relax && cur_reached_ff |=> cur_reached_ff && (cur_best_ff >= $past(cur_best_ff)))
      else $error("node best weight decreased during relaxation");

   a_walk_descends: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_wr |-> (pred_rd_ff < wn_ff))
      else $error("predecessor walk did not move to a lower label");
`endif

endmodule

`default_nettype wire
